>>> src/wspe_pkg.sv
package wspe_pkg;

  localparam int CAP_BITS      = 16;
  localparam int DEN_BITS      = CAP_BITS + 1;
  localparam int SPEED_BITS    = 16;
  localparam int SCALE_BITS    = 32;
  localparam int ACCEL_BITS    = 16;
  localparam int TICK_BITS     = 8;
  localparam int LIMIT_BITS    = ACCEL_BITS + TICK_BITS;
  localparam int REM_BITS      = DEN_BITS + 1;
  localparam int DIV_CNT_BITS  = $clog2(SCALE_BITS);
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_ADDR_BITS-1:0] CFG_SPEED_SCALE   = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_ACCEL_LIMIT   = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_TIMEOUT_TICKS = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_SPEED     = 2'd3;

  localparam logic [SCALE_BITS-1:0] SPEED_SCALE_RESET   = 32'd3063100;
  localparam logic [ACCEL_BITS-1:0] ACCEL_LIMIT_RESET   = 16'd2722;
  localparam logic [TICK_BITS-1:0]  TIMEOUT_TICKS_RESET = 8'd100;
  localparam logic [SPEED_BITS-1:0] MAX_SPEED_RESET     = 16'd20000;

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef struct packed {
    logic                op;
    logic                wheel;
    logic [CAP_BITS-1:0] capture_value;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_BITS-1:0] right_speed;
    logic [SPEED_BITS-1:0] left_speed;
    logic                  sensor_fault;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIVIDE,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic latch;
    logic tick;
    logic prime;
    logic div_start;
    logic div_step;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic primed;
    logic div_last;
  } status_t;

endpackage

>>> src/wspe_ctrl.sv
module wspe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  wspe_pkg::status_t st,
  output wspe_pkg::cmd_t    cmd
);

  wspe_pkg::state_t state;
  wspe_pkg::state_t state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wspe_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      wspe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = wspe_pkg::ST_DISPATCH;
        end
      end
      wspe_pkg::ST_DISPATCH: begin
        priority if (st.op == wspe_pkg::OP_TICK) begin
          cmd.tick   = 1'b1;
          state_next = wspe_pkg::ST_EMIT;
        end else if (!st.primed) begin
          cmd.prime  = 1'b1;
          state_next = wspe_pkg::ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = wspe_pkg::ST_DIVIDE;
        end
      end
      wspe_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = wspe_pkg::ST_UPDATE;
        end
      end
      wspe_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = wspe_pkg::ST_EMIT;
      end
      wspe_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = wspe_pkg::ST_IDLE;
        end
      end
      default: state_next = wspe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

>>> src/wspe_dp.sv
module wspe_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  wspe_pkg::in_item_t                    in_data,
  input  wspe_pkg::cmd_t                        cmd,
  output wspe_pkg::status_t                     st,
  input  logic                                  cfg_we,
  input  logic [wspe_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  logic [wspe_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output wspe_pkg::out_item_t                   out_data
);

  logic [wspe_pkg::SCALE_BITS-1:0]   speed_scale;
  logic [wspe_pkg::ACCEL_BITS-1:0]   accel_limit;
  logic [wspe_pkg::TICK_BITS-1:0]    timeout_ticks;
  logic [wspe_pkg::SPEED_BITS-1:0]   max_speed;

  logic [wspe_pkg::CAP_BITS-1:0]     last_capture [2];
  logic [wspe_pkg::SPEED_BITS-1:0]   cur_speed [2];
  logic                              primed;
  logic [wspe_pkg::TICK_BITS-1:0]    ticks;

  wspe_pkg::in_item_t                item;
  logic [wspe_pkg::LIMIT_BITS-1:0]   limit;
  logic [wspe_pkg::SCALE_BITS-1:0]   div_q;
  logic [wspe_pkg::REM_BITS-1:0]     div_rem;
  logic [wspe_pkg::DEN_BITS-1:0]     div_den;
  logic [wspe_pkg::DIV_CNT_BITS-1:0] div_cnt;

  logic [wspe_pkg::CAP_BITS-1:0]     delta_raw;
  logic [wspe_pkg::DEN_BITS-1:0]     delta;
  logic [wspe_pkg::REM_BITS-1:0]     rem_shift;
  logic                              rem_ge;
  logic [wspe_pkg::TICK_BITS-1:0]    ticks_inc;
  logic [wspe_pkg::SPEED_BITS-1:0]   q_sat;
  logic [wspe_pkg::SPEED_BITS-1:0]   old_speed;
  logic [wspe_pkg::SPEED_BITS-1:0]   rise;
  logic                              accept;

  assign delta_raw = item.capture_value - last_capture[item.wheel];
  assign delta     = (delta_raw == '0) ? {1'b1, {wspe_pkg::CAP_BITS{1'b0}}}
                                       : {1'b0, delta_raw};
  assign rem_shift = {div_rem[wspe_pkg::REM_BITS-2:0], div_q[wspe_pkg::SCALE_BITS-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_den};
  assign ticks_inc = (ticks == '1) ? ticks : ticks + 1'b1;
  assign q_sat     = (|div_q[wspe_pkg::SCALE_BITS-1:wspe_pkg::SPEED_BITS])
                     ? '1 : div_q[wspe_pkg::SPEED_BITS-1:0];
  assign old_speed = cur_speed[item.wheel];
  assign rise      = q_sat - old_speed;
  assign accept    = (q_sat < old_speed)
                     || ({{(wspe_pkg::LIMIT_BITS-wspe_pkg::SPEED_BITS){1'b0}}, rise} < limit);

  assign st.op       = item.op;
  assign st.primed   = primed;
  assign st.div_last = (div_cnt == wspe_pkg::DIV_CNT_BITS'(wspe_pkg::SCALE_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale   <= wspe_pkg::SPEED_SCALE_RESET;
      accel_limit   <= wspe_pkg::ACCEL_LIMIT_RESET;
      timeout_ticks <= wspe_pkg::TIMEOUT_TICKS_RESET;
      max_speed     <= wspe_pkg::MAX_SPEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        wspe_pkg::CFG_SPEED_SCALE:   speed_scale   <= cfg_data;
        wspe_pkg::CFG_ACCEL_LIMIT:   accel_limit   <= cfg_data[wspe_pkg::ACCEL_BITS-1:0];
        wspe_pkg::CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[wspe_pkg::TICK_BITS-1:0];
        wspe_pkg::CFG_MAX_SPEED:     max_speed     <= cfg_data[wspe_pkg::SPEED_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_capture[0] <= '0;
      last_capture[1] <= '0;
      cur_speed[0]    <= '0;
      cur_speed[1]    <= '0;
      primed          <= 1'b0;
      ticks           <= '0;
    end else begin
      if (cmd.tick) begin
        ticks <= ticks_inc;
        if (ticks_inc >= timeout_ticks) begin
          cur_speed[0] <= '0;
          cur_speed[1] <= '0;
          primed       <= 1'b0;
        end
      end
      if (cmd.prime) begin
        ticks  <= '0;
        primed <= 1'b1;
      end
      if (cmd.div_start) begin
        ticks <= '0;
      end
      if (cmd.update) begin
        last_capture[item.wheel] <= item.capture_value;
        if (accept) begin
          cur_speed[item.wheel] <= q_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item <= in_data;
    end
    if (cmd.div_start) begin
      limit   <= wspe_pkg::LIMIT_BITS'(accel_limit) * wspe_pkg::LIMIT_BITS'(ticks);
      div_q   <= speed_scale;
      div_rem <= '0;
      div_den <= delta;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      div_rem <= rem_ge ? rem_shift - {1'b0, div_den} : rem_shift;
      div_q   <= {div_q[wspe_pkg::SCALE_BITS-2:0], rem_ge};
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.emit) begin
      out_data.right_speed  <= cur_speed[0];
      out_data.left_speed   <= cur_speed[1];
      out_data.sensor_fault <= (cur_speed[0] > max_speed) || (cur_speed[1] > max_speed);
    end
  end

endmodule

>>> src/wheel_speed_period_estimator_unit.sv
// Two-wheel speed estimator by input-capture period measurement. Each input beat is a
// capture (wheel select and 16-bit timer value) or a control-loop tick, and each gives
// one output beat with both speeds in 0.01 km/h and a fault flag. A tick or the first
// capture after reset or timeout goes through the dispatch and emit states, emit
// loading the output register; a primed capture goes through dispatch, divide,
// update and emit, divide running the 32-step shift-subtract divider that forms
// speed_scale / delta one quotient bit per cycle. One item is in work at a time;
// the output register lets the next item be accepted while a result still waits.
// Configuration is written through cfg_we / cfg_addr / cfg_data while idle.
module wheel_speed_period_estimator_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  wspe_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output wspe_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [wspe_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [wspe_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  wspe_pkg::cmd_t    cmd;
  wspe_pkg::status_t st;

  wspe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  wspe_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .st       (st),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in work");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid || out_ready)
    else $error("result loaded over a pending output beat");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.latch, cmd.tick, cmd.prime, cmd.div_start, cmd.div_step,
              cmd.update, cmd.emit}))
    else $error("more than one datapath command at once");

  a_div_end: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step && st.div_last |=> cmd.update)
    else $error("divider finished without speed update");

endmodule

>>> bench/wheel_speed_period_estimator_unit_tb.sv
`timescale 1ns / 100ps

module wheel_speed_period_estimator_unit_tb;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  wspe_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  wspe_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [wspe_pkg::CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [wspe_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  wheel_speed_period_estimator_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  wspe_pkg::in_item_t pending_items[$];
  wspe_pkg::out_item_t expected_speeds[$];

  // predictor copy of the block
  logic [wspe_pkg::SCALE_BITS-1:0] scale_cfg = wspe_pkg::SPEED_SCALE_RESET;
  logic [wspe_pkg::ACCEL_BITS-1:0] accel_cfg = wspe_pkg::ACCEL_LIMIT_RESET;
  logic [wspe_pkg::TICK_BITS-1:0] timeout_cfg = wspe_pkg::TIMEOUT_TICKS_RESET;
  logic [wspe_pkg::SPEED_BITS-1:0] max_cfg = wspe_pkg::MAX_SPEED_RESET;
  logic [wspe_pkg::CAP_BITS-1:0] prev_capture[2];
  logic [wspe_pkg::SPEED_BITS-1:0] speed_est[2];
  logic armed = 1'b0;
  logic [wspe_pkg::TICK_BITS-1:0] tick_count = '0;

  int n_err = 0;
  int n_in = 0;
  int n_out = 0;
  int n_cap = 0;
  int n_tick = 0;
  int n_update = 0;
  int n_reject = 0;
  int n_timeout = 0;
  int n_fault = 0;
  int n_settings = 0;
  logic in_accepted = 1'b0;
  int idle_cycles = 0;
  wspe_pkg::out_item_t want;

  // stimulus shaping
  logic [wspe_pkg::CAP_BITS-1:0] timer_now[2];
  int period_nom[2];

  function automatic wspe_pkg::out_item_t predict_speeds(wspe_pkg::in_item_t it);
    logic [wspe_pkg::TICK_BITS-1:0] elapsed;
    logic [wspe_pkg::CAP_BITS-1:0] diff;
    logic [wspe_pkg::DEN_BITS-1:0] den;
    logic [wspe_pkg::SCALE_BITS-1:0] quo;
    logic [wspe_pkg::SPEED_BITS-1:0] q16;
    int rise;
    int lim;
    wspe_pkg::out_item_t r;
    if (it.op == wspe_pkg::OP_CAPTURE) begin
      n_cap++;
      elapsed = tick_count;
      tick_count = '0;
      if (!armed) begin
        armed = 1'b1;
      end else begin
        diff = it.capture_value - prev_capture[it.wheel];
        den = (diff == '0) ? {1'b1, {wspe_pkg::CAP_BITS{1'b0}}} : {1'b0, diff};
        quo = scale_cfg / {{(wspe_pkg::SCALE_BITS-wspe_pkg::DEN_BITS){1'b0}}, den};
        q16 = (quo > 32'h0000_FFFF) ? 16'hFFFF : quo[wspe_pkg::SPEED_BITS-1:0];
        rise = int'({16'd0, q16}) - int'({16'd0, speed_est[it.wheel]});
        lim = int'({16'd0, accel_cfg}) * int'({24'd0, elapsed});
        if (rise < lim) begin
          speed_est[it.wheel] = q16;
          n_update++;
        end else begin
          n_reject++;
        end
        prev_capture[it.wheel] = it.capture_value;
      end
    end else begin
      n_tick++;
      if (tick_count != 8'hFF) tick_count++;
      if (tick_count >= timeout_cfg) begin
        speed_est[0] = '0;
        speed_est[1] = '0;
        armed = 1'b0;
        n_timeout++;
      end
    end
    r.right_speed = speed_est[0];
    r.left_speed = speed_est[1];
    r.sensor_fault = (speed_est[0] > max_cfg) || (speed_est[1] > max_cfg);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_err++;
    end
  endfunction

  // monitor and predictor
  always @(posedge clk) begin
    if (rst) begin
      prev_capture[0] = '0;
      prev_capture[1] = '0;
      speed_est[0] = '0;
      speed_est[1] = '0;
      armed = 1'b0;
      tick_count = '0;
      in_accepted <= 1'b0;
      idle_cycles = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          wspe_pkg::CFG_SPEED_SCALE: scale_cfg = cfg_data[wspe_pkg::SCALE_BITS-1:0];
          wspe_pkg::CFG_ACCEL_LIMIT: accel_cfg = cfg_data[wspe_pkg::ACCEL_BITS-1:0];
          wspe_pkg::CFG_TIMEOUT_TICKS: timeout_cfg = cfg_data[wspe_pkg::TICK_BITS-1:0];
          wspe_pkg::CFG_MAX_SPEED: max_cfg = cfg_data[wspe_pkg::SPEED_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        n_out++;
        if (out_data.sensor_fault) n_fault++;
        if (expected_speeds.size() == 0) begin
          $error("output beat with no pending expectation");
          n_err++;
        end else begin
          want = expected_speeds.pop_front();
          check_field("right_speed", want.right_speed, out_data.right_speed);
          check_field("left_speed", want.left_speed, out_data.left_speed);
          check_field("sensor_fault", want.sensor_fault, out_data.sensor_fault);
        end
      end
      if (in_valid && in_ready) begin
        n_in++;
        expected_speeds.push_back(predict_speeds(in_data));
      end
      in_accepted <= in_valid && in_ready;
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // sender: bursts with gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(100, 200);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern plus one long hold
  int hold_left = 0;
  logic held = 1'b0;
  int mode = 0;
  int mode_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!held && n_in > 300 && pending_items.size() > 60) begin
      held = 1'b1;
      hold_left = 400;
      out_ready <= 1'b0;
    end else begin
      if (mode_left <= 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  task automatic push_item(logic op, logic wh, logic [wspe_pkg::CAP_BITS-1:0] cap);
    wspe_pkg::in_item_t it;
    it.op = op;
    it.wheel = wh;
    it.capture_value = cap;
    pending_items.push_back(it);
  endtask

  task automatic push_noise_tick();
    push_item(wspe_pkg::OP_TICK, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic cfg_write(logic [wspe_pkg::CFG_ADDR_BITS-1:0] addr,
                           logic [wspe_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] scale, logic [15:0] accel, logic [7:0] tmo,
                            logic [15:0] maxs);
    cfg_write(wspe_pkg::CFG_SPEED_SCALE, scale);
    cfg_write(wspe_pkg::CFG_ACCEL_LIMIT, {16'd0, accel});
    cfg_write(wspe_pkg::CFG_TIMEOUT_TICKS, {24'd0, tmo});
    cfg_write(wspe_pkg::CFG_MAX_SPEED, {16'd0, maxs});
    n_settings++;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_speeds.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // mostly tick runs followed by a plausible capture, some timeout runs and noise
  task automatic add_traffic(int n, int tick_max, int tmo);
    int added;
    int sel;
    int k;
    int cnt;
    int dlt;
    logic w;
    added = 0;
    while (added < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        cnt = $urandom_range(0, tick_max);
        repeat (cnt) push_noise_tick();
        w = 1'($urandom_range(0, 1));
        k = $urandom_range(0, 9);
        if (k == 0) begin
          dlt = $urandom_range(1, 160);
        end else if (k == 1) begin
          dlt = 0;
        end else if (k == 2) begin
          dlt = $urandom_range(3000, 65535);
        end else begin
          period_nom[w] = period_nom[w] + $urandom_range(0, 100) - 50;
          if (period_nom[w] < 150) period_nom[w] = 150;
          if (period_nom[w] > 3000) period_nom[w] = 3000;
          dlt = period_nom[w];
        end
        timer_now[w] = timer_now[w] + dlt[wspe_pkg::CAP_BITS-1:0];
        push_item(wspe_pkg::OP_CAPTURE, w, timer_now[w]);
        added += cnt + 1;
      end else if (sel < 85) begin
        cnt = $urandom_range(1, (tmo > 40) ? 40 : tmo + 3);
        repeat (cnt) push_noise_tick();
        added += cnt;
      end else begin
        push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)));
        added++;
      end
    end
  endtask

  initial begin
    timer_now[0] = '0;
    timer_now[1] = '0;
    period_nom[0] = 1000;
    period_nom[1] = 1500;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at reset settings
    push_item(wspe_pkg::OP_TICK, 1'b1, 16'hFFFF);
    push_item(wspe_pkg::OP_CAPTURE, 1'b0, 16'h0000);
    push_item(wspe_pkg::OP_CAPTURE, 1'b0, 16'h0000);
    push_item(wspe_pkg::OP_TICK, 1'b0, 16'h0000);
    push_item(wspe_pkg::OP_TICK, 1'b1, 16'hAAAA);
    push_item(wspe_pkg::OP_CAPTURE, 1'b0, 16'd1000);
    push_item(wspe_pkg::OP_CAPTURE, 1'b0, 16'd1000);
    push_item(wspe_pkg::OP_CAPTURE, 1'b1, 16'hFFFF);
    push_item(wspe_pkg::OP_TICK, 1'b0, 16'h5555);
    push_item(wspe_pkg::OP_CAPTURE, 1'b1, 16'h0010);
    push_item(wspe_pkg::OP_CAPTURE, 1'b1, 16'h0BC8);
    push_item(wspe_pkg::OP_CAPTURE, 1'b0, 16'd1001);
    push_item(wspe_pkg::OP_TICK, 1'b0, 16'h0000);
    push_item(wspe_pkg::OP_TICK, 1'b0, 16'h0000);
    push_item(wspe_pkg::OP_TICK, 1'b0, 16'h0000);
    push_item(wspe_pkg::OP_CAPTURE, 1'b0, 16'd1901);
    push_item(wspe_pkg::OP_CAPTURE, 1'b1, 16'h8000);
    wait_idle();

    set_config(32'd3063100, 16'd2722, 8'd20, 16'd20000);
    add_traffic(130, 4, 20);
    wait_idle();

    set_config(32'hFFFF_FFFF, 16'hFFFF, 8'd255, 16'd0);
    add_traffic(120, 4, 255);
    repeat (260) push_noise_tick();
    add_traffic(10, 2, 255);
    wait_idle();

    set_config(32'd0, 16'd0, 8'd1, 16'hFFFF);
    add_traffic(130, 3, 1);
    wait_idle();

    set_config($urandom, 16'($urandom_range(0, 65535)), 8'd0,
               16'($urandom_range(0, 65535)));
    add_traffic(130, 3, 0);
    wait_idle();

    set_config($urandom_range(500000, 20000000), 16'($urandom_range(0, 3000)),
               8'($urandom_range(3, 40)), 16'($urandom_range(5000, 40000)));
    add_traffic(130, 5, 20);
    wait_idle();

    set_config(32'd3063100, 16'd2722, 8'd8, 16'd20000);
    add_traffic(130, 4, 8);
    wait_idle();

    if (expected_speeds.size() != 0) begin
      $error("%0d expected beats never arrived", expected_speeds.size());
      n_err++;
    end
    $display("run: %0d input beats (%0d captures, %0d ticks), %0d output beats, %0d settings",
             n_in, n_cap, n_tick, n_out, n_settings);
    $display("run: %0d speed updates, %0d rejected rises, %0d timeouts, %0d fault beats",
             n_update, n_reject, n_timeout, n_fault);
    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
